@@ rtl/wbss_pkg.sv @@
// Shared types and constants for the wildcard byte signature scanner.
`timescale 1ns / 1ps
`default_nettype none

package wbss_pkg;

    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 5;
    localparam int PATTERN_W     = 64;
    localparam int CARE_W        = 16;
    localparam int LEN_W         = 5;
    localparam int DATA_W        = 8;
    localparam int ADDR_W        = 32;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 32;

    typedef enum logic [1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_CARE_MASK    = 2'd2,
        REG_PATTERN_LEN  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [PATTERN_W-1:0] pattern_low;
        logic [PATTERN_W-1:0] pattern_high;
        logic [CARE_W-1:0]    care_mask;
        logic [LEN_W-1:0]     pattern_length;
    } t_cfg;

    typedef struct packed {
        logic              emit;
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } t_step_res;

endpackage

`default_nettype wire

@@ rtl/wildcard_byte_signature_scanner_unit.sv @@
// Top level of the wildcard byte signature scanner: stream stages, matcher and registers.
//
// Channel   Direction  Handshake                Payload
// s stream  in         i_s_tvalid / o_s_tready  tdata = data_byte, byte_address; tlast = last_byte
// m stream  out        o_m_tvalid / i_m_tready  tdata = match_address; tuser = found
// apb       in         psel, penable, pready    registers at byte addresses 0, 8, 16, 24
//
// Each byte is compared while it sits in the input register, and any result it produces is
// written to the output register as the byte leaves; one byte per cycle is sustained while
// the output is not stalled. A result is offered from the output register.
// Reset clears the region state, the stage valid flags and the registers to their defaults.
// A stalled output holds the matcher and input register while the result waits.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_signature_scanner_unit #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // [7:0] data_byte, [39:8] byte_address
    input  wire logic [wbss_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  wire logic                                i_s_tlast,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // [31:0] match_address
    output logic      [wbss_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // [0] found
    output logic                                     o_m_tuser,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [wbss_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [wbss_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [wbss_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    wbss_pkg::t_cfg               cfg;
    wbss_pkg::t_step_res          step_res;
    logic                         r_in_valid;
    logic [wbss_pkg::DATA_W-1:0]  r_in_data;
    logic [wbss_pkg::ADDR_W-1:0]  r_in_addr;
    logic                         r_in_last;
    logic                         r_out_valid;
    logic                         r_out_found;
    logic [wbss_pkg::ADDR_W-1:0]  r_out_addr;
    logic                         advance;
    logic                         in_take;

    wbss_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    wbss_matcher #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_matcher (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (advance),
        .i_data  (r_in_data),
        .i_addr  (r_in_addr),
        .i_last  (r_in_last),
        .o_res   (step_res)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_s_tdata[wbss_pkg::DATA_W-1:0];
            r_in_addr <= i_s_tdata[wbss_pkg::DATA_W +: wbss_pkg::ADDR_W];
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_res.emit;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_res.emit) begin
            r_out_found <= step_res.found;
            r_out_addr  <= step_res.match_address;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_addr;
    assign o_m_tuser  = r_out_found;

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("A not-found result carries a nonzero address.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready))
        else $error("Input stalled although the pipeline can move.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("A waiting result changed before its transaction.");

endmodule

`default_nettype wire

@@ rtl/wbss_cfg_regs.sv @@
// APB register file holding the pattern, care mask and pattern length.
`timescale 1ns / 1ps
`default_nettype none

module wbss_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [wbss_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [wbss_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [wbss_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output wbss_pkg::t_cfg                        o_cfg
);

    logic [wbss_pkg::PATTERN_W-1:0] r_pattern_low;
    logic [wbss_pkg::PATTERN_W-1:0] r_pattern_high;
    logic [wbss_pkg::CARE_W-1:0]    r_care_mask;
    logic [wbss_pkg::LEN_W-1:0]     r_pattern_length;
    wbss_pkg::t_reg_idx             reg_idx;
    logic                           wr_en;

    assign reg_idx = wbss_pkg::t_reg_idx'(paddr[wbss_pkg::CFG_ADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_care_mask      <= '1;
            r_pattern_length <= wbss_pkg::LEN_W'(1);
        end else if (wr_en) begin
            unique case (reg_idx)
                wbss_pkg::REG_PATTERN_LOW:  r_pattern_low    <= pwdata;
                wbss_pkg::REG_PATTERN_HIGH: r_pattern_high   <= pwdata;
                wbss_pkg::REG_CARE_MASK:    r_care_mask      <= pwdata[wbss_pkg::CARE_W-1:0];
                wbss_pkg::REG_PATTERN_LEN:  r_pattern_length <= pwdata[wbss_pkg::LEN_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            wbss_pkg::REG_PATTERN_LOW:  prdata = r_pattern_low;
            wbss_pkg::REG_PATTERN_HIGH: prdata = r_pattern_high;
            wbss_pkg::REG_CARE_MASK:
                prdata = {{(wbss_pkg::CFG_DATA_W-wbss_pkg::CARE_W){1'b0}}, r_care_mask};
            wbss_pkg::REG_PATTERN_LEN:
                prdata = {{(wbss_pkg::CFG_DATA_W-wbss_pkg::LEN_W){1'b0}}, r_pattern_length};
        endcase
    end

    assign o_cfg.pattern_low    = r_pattern_low;
    assign o_cfg.pattern_high   = r_pattern_high;
    assign o_cfg.care_mask      = r_care_mask;
    assign o_cfg.pattern_length = r_pattern_length;

endmodule

`default_nettype wire

@@ rtl/wbss_matcher.sv @@
// Byte window, region tracking and parallel wildcard compare for one byte per step.
`timescale 1ns / 1ps
`default_nettype none

module wbss_matcher #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire wbss_pkg::t_cfg                 i_cfg,
    input  wire logic                           i_step,
    input  wire logic [wbss_pkg::DATA_W-1:0]    i_data,
    input  wire logic [wbss_pkg::ADDR_W-1:0]    i_addr,
    input  wire logic                           i_last,
    output wbss_pkg::t_step_res                 o_res
);

    localparam int SEEN_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_W  = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [wbss_pkg::DATA_W-1:0] r_window [MAX_PATTERN_BYTES];
    logic [wbss_pkg::DATA_W-1:0] n_window [MAX_PATTERN_BYTES];
    logic [SEEN_W-1:0]           r_seen;
    logic [SEEN_W-1:0]           n_seen;
    logic                        r_reported;
    logic                        n_reported;
    logic [wbss_pkg::LEN_W-1:0]  len_use;
    logic [2*wbss_pkg::PATTERN_W-1:0] pattern_all;
    logic                        window_ok;
    logic                        is_match;

    assign pattern_all = {i_cfg.pattern_high, i_cfg.pattern_low};

    always_comb begin
        priority if (i_cfg.pattern_length == '0)
            len_use = wbss_pkg::LEN_W'(1);
        else if (i_cfg.pattern_length > wbss_pkg::LEN_W'(MAX_PATTERN_BYTES))
            len_use = wbss_pkg::LEN_W'(MAX_PATTERN_BYTES);
        else
            len_use = i_cfg.pattern_length;
    end

    always_comb begin
        n_window[0] = i_data;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
            n_window[k] = r_window[k-1];
        end
        n_seen = (r_seen == SEEN_W'(MAX_PATTERN_BYTES)) ? r_seen : r_seen + SEEN_W'(1);
    end

    always_comb begin
        logic [wbss_pkg::LEN_W-1:0] pos;
        window_ok = 1'b1;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            pos = len_use - wbss_pkg::LEN_W'(1) - wbss_pkg::LEN_W'(i);
            if ((wbss_pkg::LEN_W'(i) < len_use) && i_cfg.care_mask[i]) begin
                if (n_window[pos[IDX_W-1:0]] != pattern_all[8*i +: 8])
                    window_ok = 1'b0;
            end
        end
    end

    assign is_match = (wbss_pkg::LEN_W'(n_seen) >= len_use) && window_ok;

    always_comb begin
        o_res.emit          = 1'b0;
        o_res.found         = 1'b0;
        o_res.match_address = '0;
        n_reported          = r_reported;
        if (!r_reported) begin
            if (is_match) begin
                o_res.emit          = 1'b1;
                o_res.found         = 1'b1;
                o_res.match_address = i_addr - wbss_pkg::ADDR_W'(len_use)
                                      + wbss_pkg::ADDR_W'(1);
                n_reported          = 1'b1;
            end else if (i_last) begin
                o_res.emit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_reported <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_seen     <= '0;
                r_reported <= 1'b0;
            end else if (!r_reported) begin
                r_seen     <= n_seen;
                r_reported <= n_reported;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && !r_reported) begin
            r_window <= n_window;
        end
    end

    a_region_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last) |=> (r_seen == '0 && !r_reported))
        else $error("Region state not cleared after the final byte.");

    a_silent_after_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reported |-> !o_res.emit)
        else $error("Result produced after a match was already reported.");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_W'(MAX_PATTERN_BYTES))
        else $error("Byte count exceeds the window depth.");

endmodule

`default_nettype wire

@@ verif/wildcard_byte_signature_scanner_unit_test.sv @@
// Self-checking testbench for the wildcard byte signature scanner unit.
`timescale 1ns / 1ps

module wildcard_byte_signature_scanner_unit_test;

    typedef struct packed {
        logic                        found;
        logic [wbss_pkg::ADDR_W-1:0] match_address;
    } t_scan_hit;

    typedef struct {
        bit                  is_write;
        wbss_pkg::t_reg_idx  reg_sel;
        logic [63:0]         value;
        logic [7:0]          data;
        logic [31:0]         addr;
        bit                  last;
        int                  exp_kind;
        t_scan_hit           exp_hit;
    } t_stim_row;

    logic                             i_clk;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_tvalid = 1'b0;
    logic                             o_s_tready;
    logic [wbss_pkg::IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                             i_s_tlast = 1'b0;
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    logic [wbss_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic                             o_m_tuser;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [wbss_pkg::CFG_ADDR_W-1:0]  paddr = '0;
    logic [wbss_pkg::CFG_DATA_W-1:0]  pwdata = '0;
    logic [wbss_pkg::CFG_DATA_W-1:0]  prdata;
    logic                             pready;

    wildcard_byte_signature_scanner_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    logic [63:0] cfg_pat_lo = '0;
    logic [63:0] cfg_pat_hi = '0;
    logic [15:0] cfg_care = 16'hFFFF;
    logic [4:0]  cfg_len = 5'd1;

    logic [7:0]  scan_window [16] = '{default: 8'h00};
    int          scan_seen = 0;
    bit          scan_done = 1'b0;

    t_scan_hit   expected_hits [$];
    t_stim_row   directed_rows [$];
    int          mismatch_count = 0;
    int          bytes_scanned = 0;
    bit          sender_calm = 1'b0;
    logic        hold_req = 1'b0;
    bit          hold_taken = 1'b0;
    int          stall_left = 0;
    int          calm_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int active_length();
        if (cfg_len == 0) return 1;
        if (cfg_len > 16) return 16;
        return int'(cfg_len);
    endfunction

    function automatic logic [7:0] pattern_byte(input int k);
        logic [127:0] full;
        full = {cfg_pat_hi, cfg_pat_lo};
        return full[8*k +: 8];
    endfunction

    function automatic void clear_scan_state();
        scan_window = '{default: 8'h00};
        scan_seen = 0;
        scan_done = 1'b0;
    endfunction

    function automatic void scan_byte(input logic [7:0] d, input logic [31:0] a, input bit l,
                                      output bit has, output t_scan_hit hit);
        int len;
        int k;
        bit ok;
        has = 1'b0;
        hit = '0;
        if (!scan_done) begin
            len = active_length();
            for (k = 15; k > 0; k--) scan_window[k] = scan_window[k-1];
            scan_window[0] = d;
            if (scan_seen < 16) scan_seen++;
            ok = (scan_seen >= len);
            for (k = 0; k < len; k++) begin
                if (cfg_care[k] && scan_window[len-1-k] != pattern_byte(k)) ok = 1'b0;
            end
            if (ok) begin
                scan_done = 1'b1;
                has = 1'b1;
                hit.found = 1'b1;
                hit.match_address = a - 32'(len - 1);
            end else if (l) begin
                has = 1'b1;
            end
        end
        if (l) clear_scan_state();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t ns: %s got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Result checking and receiver back-pressure share one process.
    always @(posedge i_clk) begin : result_side
        int unsigned roll;
        t_scan_hit want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_hits.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata, '0);
            end else begin
                want = expected_hits.pop_front();
                if (o_m_tuser !== want.found)
                    report_mismatch("found", 32'(o_m_tuser), 32'(want.found));
                if (o_m_tdata !== want.match_address)
                    report_mismatch("match_address", o_m_tdata, want.match_address);
            end
        end
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (calm_left > 0) begin
            calm_left--;
            i_m_tready <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                calm_left = $urandom_range(50, 150);
                i_m_tready <= 1'b1;
            end else if (roll < 80) begin
                i_m_tready <= 1'b1;
            end else if (roll < 97) begin
                stall_left = $urandom_range(0, 3);
                i_m_tready <= 1'b0;
            end else begin
                stall_left = $urandom_range(20, 60);
                i_m_tready <= 1'b0;
            end
        end
    end

    function automatic int pick_gap();
        int unsigned roll;
        if (sender_calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 75) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic push_byte(input logic [7:0] d, input logic [31:0] a, input bit l,
                             input int exp_kind, input t_scan_hit typed);
        int gap;
        bit has;
        t_scan_hit hit;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {a, d};
        i_s_tlast <= l;
        do @(posedge i_clk); while (!o_s_tready);
        scan_byte(d, a, l, has, hit);
        if (exp_kind > 0) expected_hits.push_back(typed);
        else if (exp_kind < 0 && has) expected_hits.push_back(hit);
        bytes_scanned++;
    endtask

    task automatic settle_block();
        i_s_tvalid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input wbss_pkg::t_reg_idx idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            wbss_pkg::REG_PATTERN_LOW:  cfg_pat_lo = value;
            wbss_pkg::REG_PATTERN_HIGH: cfg_pat_hi = value;
            wbss_pkg::REG_CARE_MASK:    cfg_care = value[15:0];
            wbss_pkg::REG_PATTERN_LEN:  cfg_len = value[4:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [15:0] care, input logic [4:0] len);
        settle_block();
        write_reg(wbss_pkg::REG_PATTERN_LOW, lo);
        write_reg(wbss_pkg::REG_PATTERN_HIGH, hi);
        write_reg(wbss_pkg::REG_CARE_MASK, 64'(care));
        write_reg(wbss_pkg::REG_PATTERN_LEN, 64'(len));
    endtask

    function automatic void add_write(input wbss_pkg::t_reg_idx idx, input logic [63:0] value);
        t_stim_row row;
        row = '{is_write: 1'b1, reg_sel: idx, value: value, data: '0, addr: '0, last: 1'b0,
                exp_kind: 0, exp_hit: '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_byte(input logic [7:0] d, input logic [31:0] a, input bit l,
                                     input int kind, input bit found, input logic [31:0] ma);
        t_stim_row row;
        row = '{is_write: 1'b0, reg_sel: wbss_pkg::REG_PATTERN_LOW, value: '0, data: d,
                addr: a, last: l, exp_kind: kind, exp_hit: '{found, ma}};
        directed_rows.push_back(row);
    endfunction

    task automatic run_region();
        logic [7:0] body [64];
        int unsigned roll;
        int n;
        int pos;
        int len;
        int k;
        logic [31:0] base;
        logic [31:0] a;
        bit noise;
        bit cut;
        bit l;
        roll = $urandom_range(0, 99);
        n = (roll < 85) ? $urandom_range(1, 24) : $urandom_range(25, 60);
        roll = $urandom_range(0, 99);
        if (roll < 10) base = 32'hFFFF_FFFF - $urandom_range(0, 20);
        else if (roll < 15) base = '0;
        else base = $urandom;
        noise = ($urandom_range(0, 9) == 0);
        cut = ($urandom_range(0, 19) == 0);
        for (k = 0; k < n; k++) body[k] = 8'($urandom);
        len = active_length();
        if (!noise && n >= len && $urandom_range(0, 99) < 65) begin
            pos = $urandom_range(0, n - len);
            for (k = 0; k < len; k++) begin
                if (cfg_care[k]) body[pos+k] = pattern_byte(k);
            end
            if ($urandom_range(0, 4) == 0) begin
                k = $urandom_range(0, len - 1);
                body[pos+k] = body[pos+k] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
        for (k = 0; k < n; k++) begin
            a = noise ? 32'($urandom) : base + 32'(k);
            l = (k == n - 1) && !cut;
            if (noise && $urandom_range(0, 15) == 0) l = 1'b1;
            push_byte(body[k], a, l, -1, '0);
        end
    endtask

    initial begin : stimulus
        int phase;
        int start;
        int budget;
        int k;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [15:0] care;
        logic [4:0] len;

        add_byte(8'h00, 32'h0000_0000, 1'b0, 1, 1'b1, 32'h0000_0000);
        add_byte(8'hFF, 32'h0000_0001, 1'b1, 0, 1'b0, '0);
        add_byte(8'hFF, 32'hFFFF_FFFF, 1'b1, 1, 1'b0, '0);
        add_write(wbss_pkg::REG_PATTERN_LEN, 64'd0);
        add_write(wbss_pkg::REG_PATTERN_LOW, 64'h0000_0000_0000_00A5);
        add_byte(8'h5A, 32'd10, 1'b0, 0, 1'b0, '0);
        add_byte(8'hA5, 32'd11, 1'b1, 1, 1'b1, 32'd11);
        add_write(wbss_pkg::REG_PATTERN_LOW, 64'h0706_0504_0302_0100);
        add_write(wbss_pkg::REG_PATTERN_HIGH, 64'h0F0E_0D0C_0B0A_0908);
        add_write(wbss_pkg::REG_PATTERN_LEN, 64'd31);
        for (k = 0; k < 15; k++) add_byte(8'(k), 32'hFFFF_FFF8 + 32'(k), 1'b0, 0, 1'b0, '0);
        add_byte(8'h0F, 32'h0000_0007, 1'b0, 1, 1'b1, 32'hFFFF_FFF8);
        add_byte(8'h3C, 32'h0000_0008, 1'b1, 0, 1'b0, '0);
        add_write(wbss_pkg::REG_PATTERN_LEN, 64'd2);
        add_write(wbss_pkg::REG_CARE_MASK, 64'h0000_0000_0000_FFFD);
        add_byte(8'h00, 32'd100, 1'b0, 0, 1'b0, '0);
        add_byte(8'h7E, 32'd101, 1'b1, 1, 1'b1, 32'd100);
        add_byte(8'h55, 32'd200, 1'b0, 0, 1'b0, '0);
        add_write(wbss_pkg::REG_PATTERN_LOW, 64'h0000_0000_0000_6655);
        add_write(wbss_pkg::REG_CARE_MASK, 64'h0000_0000_0000_FFFF);
        add_byte(8'h66, 32'd201, 1'b1, 1, 1'b1, 32'd200);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_write) begin
                settle_block();
                write_reg(directed_rows[r].reg_sel, directed_rows[r].value);
            end else begin
                push_byte(directed_rows[r].data, directed_rows[r].addr, directed_rows[r].last,
                          directed_rows[r].exp_kind, directed_rows[r].exp_hit);
            end
        end

        phase = 0;
        bytes_scanned = 0;
        while (bytes_scanned < 1950) begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            case ($urandom_range(0, 9))
                0: len = 5'd0;
                1: len = 5'($urandom_range(17, 31));
                2: len = 5'd16;
                3: len = 5'd1;
                default: len = 5'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 3))
                0: care = 16'hFFFF;
                1: care = ~(16'h0001 << $urandom_range(0, 15));
                2: care = 16'($urandom);
                default: care = 16'hFFFF ^ (16'($urandom) & 16'($urandom) & 16'($urandom));
            endcase
            case (phase)
                0: begin
                    lo = '1;
                    hi = '1;
                    care = 16'hFFFF;
                    len = 5'd16;
                end
                1: begin
                    care = 16'h0000;
                    len = 5'd1;
                end
                2: begin
                    care = 16'h0000;
                    len = 5'd31;
                end
                3: begin
                    lo = '0;
                    hi = '0;
                    len = 5'd0;
                end
                default: ;
            endcase
            apply_setting(lo, hi, care, len);
            sender_calm = (phase == 4) || ($urandom_range(0, 3) == 0);
            if (phase == 4) hold_req <= 1'b1;
            budget = $urandom_range(60, 140);
            start = bytes_scanned;
            while (bytes_scanned - start < budget) run_region();
            phase++;
        end

        settle_block();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_hits.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
